[hdl/b64c_pkg.sv]
// Shared types, register codes and character tables of the Base64 codec.
// No dependencies; every other file of the block uses this package.
package b64c_pkg;

    localparam int unsigned JobSlots = 4;

    localparam logic [7:0] CHAR_PAD     = 8'h3D;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       out_end;
        logic       out_error;
    } result_t;

    typedef enum logic [1:0] {
        REG_DECODE_MODE    = 2'd0,
        REG_IGNORE_INVALID = 2'd1,
        REG_LINE_LENGTH    = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic decode_mode;
        logic ignore_invalid;
    } front_cfg_t;

    // One accepted item, ready for output: up to four characters or bytes
    typedef struct packed {
        logic [JobSlots-1:0][7:0] data;
        logic [2:0]               count;
        logic                     text;
        logic                     err;
        logic                     last;
    } job_t;

    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (v < 6'd26)
            return 8'h41 + w;
        else if (v < 6'd52)
            return 8'h61 + (w - 8'd26);
        else if (v < 6'd62)
            return 8'h30 + (w - 8'd52);
        else if (v == 6'd62)
            return 8'h2B;
        else
            return 8'h2F;
    endfunction

    // Returns {valid, sextet}
    function automatic logic [6:0] char_sextet(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A)
            return {1'b1, 6'(c - 8'h41)};
        else if (c >= 8'h61 && c <= 8'h7A)
            return {1'b1, 6'(c - 8'h61 + 8'd26)};
        else if (c >= 8'h30 && c <= 8'h39)
            return {1'b1, 6'(c - 8'h30 + 8'd52)};
        else if (c == 8'h2B)
            return {1'b1, 6'd62};
        else if (c == 8'h2F)
            return {1'b1, 6'd63};
        else
            return 7'd0;
    endfunction

endpackage

[hdl/b64c_front.sv]
// Front end of the Base64 codec: accepts items, keeps the group state and
// turns each item into a job for the queue. Depends on b64c_pkg.
module b64c_front (
    input  logic                clk,
    input  logic                rst_n,
    input  b64c_pkg::front_cfg_t cfg,
    input  logic                item_valid,
    output logic                item_stall,
    input  b64c_pkg::item_t     item,
    output logic                job_valid,
    input  logic                job_full,
    output b64c_pkg::job_t      job
);

    logic [23:0] group_bits_reg;
    logic [23:0] group_bits_next;
    logic [1:0]  group_count_reg;
    logic [1:0]  group_count_next;
    logic        stopped_reg;
    logic        stopped_next;

    logic        accept;
    logic [2:0]  cnt;
    logic [23:0] enc_shift;
    logic [6:0]  dec_sx;
    logic [23:0] dec_shift;
    b64c_pkg::job_t job_c;

    function automatic b64c_pkg::job_t add_flush(input b64c_pkg::job_t j,
                                                 input logic [1:0] gc,
                                                 input logic [23:0] gb);
        b64c_pkg::job_t r;
        r = j;
        if (gc == 2'd2) begin
            r.data[0] = gb[11:4];
            r.count   = 3'd1;
        end else if (gc == 2'd3) begin
            r.data[0] = gb[17:10];
            r.data[1] = gb[9:2];
            r.count   = 3'd2;
        end
        return r;
    endfunction

    assign accept     = item_valid && !job_full;
    assign item_stall = job_full;
    assign cnt        = {1'b0, group_count_reg} + 3'd1;
    assign enc_shift  = {group_bits_reg[15:0], item.in_byte};
    assign dec_sx     = b64c_pkg::char_sextet(item.in_byte);
    assign dec_shift  = {group_bits_reg[17:0], dec_sx[5:0]};

    always_comb
    begin
        group_bits_next  = group_bits_reg;
        group_count_next = group_count_reg;
        stopped_next     = stopped_reg;
        job_c            = '0;
        job_c.last       = item.in_last;
        job_c.text       = !cfg.decode_mode;
        if (!cfg.decode_mode) begin
            if (group_count_reg >= 2'd2) begin
                job_c.data[0]    = b64c_pkg::sextet_char(enc_shift[23:18]);
                job_c.data[1]    = b64c_pkg::sextet_char(enc_shift[17:12]);
                job_c.data[2]    = b64c_pkg::sextet_char(enc_shift[11:6]);
                job_c.data[3]    = b64c_pkg::sextet_char(enc_shift[5:0]);
                job_c.count      = 3'd4;
                group_bits_next  = '0;
                group_count_next = '0;
            end else begin
                group_bits_next  = enc_shift;
                group_count_next = cnt[1:0];
                if (item.in_last) begin
                    job_c.count = 3'd4;
                    if (group_count_reg == 2'd0) begin
                        job_c.data[0] = b64c_pkg::sextet_char(enc_shift[7:2]);
                        job_c.data[1] = b64c_pkg::sextet_char({enc_shift[1:0], 4'b0000});
                        job_c.data[2] = b64c_pkg::CHAR_PAD;
                        job_c.data[3] = b64c_pkg::CHAR_PAD;
                    end else begin
                        job_c.data[0] = b64c_pkg::sextet_char(enc_shift[15:10]);
                        job_c.data[1] = b64c_pkg::sextet_char(enc_shift[9:4]);
                        job_c.data[2] = b64c_pkg::sextet_char({enc_shift[3:0], 2'b00});
                        job_c.data[3] = b64c_pkg::CHAR_PAD;
                    end
                end
            end
        end else if (!stopped_reg) begin
            if (item.in_byte == b64c_pkg::CHAR_PAD) begin
                job_c            = add_flush(job_c, group_count_reg, group_bits_reg);
                group_bits_next  = '0;
                group_count_next = '0;
                stopped_next     = 1'b1;
            end else if (!dec_sx[6]) begin
                if (!cfg.ignore_invalid) begin
                    job_c.err        = 1'b1;
                    group_bits_next  = '0;
                    group_count_next = '0;
                    stopped_next     = 1'b1;
                end else if (item.in_last) begin
                    job_c = add_flush(job_c, group_count_reg, group_bits_reg);
                end
            end else if (group_count_reg == 2'd3) begin
                job_c.data[0]    = dec_shift[23:16];
                job_c.data[1]    = dec_shift[15:8];
                job_c.data[2]    = dec_shift[7:0];
                job_c.count      = 3'd3;
                group_bits_next  = '0;
                group_count_next = '0;
            end else begin
                group_bits_next  = dec_shift;
                group_count_next = cnt[1:0];
                if (item.in_last)
                    job_c = add_flush(job_c, cnt[1:0], dec_shift);
            end
        end
        if (item.in_last) begin
            group_bits_next  = '0;
            group_count_next = '0;
            stopped_next     = 1'b0;
        end
    end

    assign job       = job_c;
    assign job_valid = item_valid && (job_c.count != 3'd0 || job_c.err || job_c.last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            group_bits_reg  <= '0;
            group_count_reg <= '0;
            stopped_reg     <= 1'b0;
        end else if (accept) begin
            group_bits_reg  <= group_bits_next;
            group_count_reg <= group_count_next;
            stopped_reg     <= stopped_next;
        end
    end

endmodule

[hdl/b64c_queue.sv]
// Two-entry job queue between the front and back ends of the codec.
// Depends on b64c_pkg for the job type.
module b64c_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  b64c_pkg::job_t push_job,
    output logic           full,
    output logic           pop_valid,
    input  logic           pop,
    output b64c_pkg::job_t pop_job
);

    b64c_pkg::job_t slot_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;
    logic           do_push;
    logic           do_pop;

    assign full      = count_reg == 2'd2;
    assign pop_valid = count_reg != 2'd0;
    assign pop_job   = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 2'd1;
        else if (do_pop && !do_push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

endmodule

[hdl/b64c_back.sv]
// Back end of the codec: walks each job one result per cycle while not stalled, inserts line
// breaks and marks stream ends into the output register. Depends on b64c_pkg.
module b64c_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [15:0]      line_length,
    input  logic             job_valid,
    input  b64c_pkg::job_t   job,
    output logic             job_pop,
    output logic             result_valid,
    input  logic             result_stall,
    output b64c_pkg::result_t result
);

    logic              out_valid_reg;
    b64c_pkg::result_t out_reg;
    b64c_pkg::result_t out_next;
    logic [1:0]        idx_reg;
    logic [1:0]        idx_next;
    logic [15:0]       line_count_reg;
    logic [15:0]       line_count_next;
    logic              first_char_done_reg;
    logic              first_char_done_next;
    logic              advance;
    logic              take;
    logic              done;
    logic              final_slot;

    assign advance    = !out_valid_reg || !result_stall;
    assign take       = advance && job_valid;
    assign final_slot = {1'b0, idx_reg} == job.count - 3'd1;

    always_comb
    begin
        out_next             = '0;
        idx_next             = idx_reg;
        line_count_next      = line_count_reg;
        first_char_done_next = first_char_done_reg;
        done                 = 1'b0;
        if (job.err) begin
            out_next.out_error = 1'b1;
            out_next.out_end   = job.last;
            done               = 1'b1;
        end else if (job.count == 3'd0) begin
            out_next.out_end = 1'b1;
            done             = 1'b1;
        end else if (job.text && line_length != '0 && first_char_done_reg
                     && line_count_reg >= line_length) begin
            out_next.out_byte  = b64c_pkg::CHAR_NEWLINE;
            out_next.out_valid = 1'b1;
            line_count_next    = '0;
        end else begin
            out_next.out_byte  = job.data[idx_reg];
            out_next.out_valid = 1'b1;
            out_next.out_end   = job.last && final_slot;
            done               = final_slot;
            idx_next           = final_slot ? 2'd0 : idx_reg + 2'd1;
            if (job.text) begin
                first_char_done_next = 1'b1;
                if (line_count_reg != 16'hFFFF)
                    line_count_next = line_count_reg + 16'd1;
            end
        end
        if (done && job.last) begin
            line_count_next      = '0;
            first_char_done_next = 1'b0;
        end
    end

    assign job_pop      = take && done;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg       <= 1'b0;
            idx_reg             <= '0;
            line_count_reg      <= '0;
            first_char_done_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= job_valid;
            if (job_valid) begin
                idx_reg             <= idx_next;
                line_count_reg      <= line_count_next;
                first_char_done_reg <= first_char_done_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            out_reg <= out_next;
    end

endmodule

[hdl/base64_codec_unit.sv]
// Top level of the streaming Base64 codec: configuration registers, front
// end, job queue and back end. Depends on b64c_pkg and the b64c_* modules.
// An accepted item goes through the job queue and the output register
// before its first result shows. Items enter the two-entry job queue one per
// cycle while it is not full; results leave one per cycle unless stalled.
// Reset (rst_n low, asynchronous) clears registers, group state and queue.
module base64_codec_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    input  logic              item_valid,
    output logic              item_stall,
    input  b64c_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output b64c_pkg::result_t result
);

    logic                 decode_mode_reg;
    logic                 ignore_invalid_reg;
    logic [15:0]          line_length_reg;
    b64c_pkg::front_cfg_t front_cfg;
    logic                 push;
    logic                 full;
    logic                 pop_valid;
    logic                 pop;
    b64c_pkg::job_t       push_job;
    b64c_pkg::job_t       pop_job;

    assign cfg_ready                = 1'b1;
    assign front_cfg.decode_mode    = decode_mode_reg;
    assign front_cfg.ignore_invalid = ignore_invalid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            decode_mode_reg    <= 1'b0;
            ignore_invalid_reg <= 1'b0;
            line_length_reg    <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (b64c_pkg::cfg_reg_t'(cfg_index))
                b64c_pkg::REG_DECODE_MODE:    decode_mode_reg    <= cfg_data[0];
                b64c_pkg::REG_IGNORE_INVALID: ignore_invalid_reg <= cfg_data[0];
                b64c_pkg::REG_LINE_LENGTH:    line_length_reg    <= cfg_data;
                default:                      ;
            endcase
        end
    end

    b64c_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (front_cfg),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .job_valid  (push),
        .job_full   (full),
        .job        (push_job)
    );

    b64c_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .full      (full),
        .pop_valid (pop_valid),
        .pop       (pop),
        .pop_job   (pop_job)
    );

    b64c_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .line_length  (line_length_reg),
        .job_valid    (pop_valid),
        .job          (pop_job),
        .job_pop      (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

[hdl/b64c_checker.sv]
// Port-level checks for base64_codec_unit, bound to the top level below.
// Depends on b64c_pkg for the result type.
module b64c_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              cfg_ready,
    input logic              result_valid,
    input logic              result_stall,
    input b64c_pkg::result_t result
);

    assert property (@(posedge clk) !rst_n |-> !result_valid)
        else $error("result beat shown during reset");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result beat changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.out_error |->
            !result.out_valid && result.out_byte == 8'h00)
        else $error("error beat carries data");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.out_valid && !result.out_error |->
            result.out_end && result.out_byte == 8'h00)
        else $error("empty beat is not a bare end marker");

    assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("configuration port not ready");

endmodule

bind base64_codec_unit b64c_checker u_b64c_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_ready    (cfg_ready),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

[verif/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking bench for base64_codec_unit: encode and decode streams, register phases,
// random idling on both sides. Depends on b64c_pkg and the RTL of the codec.
module tb_top;

    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 200;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASE_ITEMS   = 12;

    class base64_mirror;
        string     alpha = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
        bit        decode_mode;
        bit        ignore_invalid;
        bit [15:0] line_length;
        bit [23:0] group_bits;
        int        group_count;
        bit [15:0] line_count;
        bit        first_char_done;
        bit        stopped;
        b64c_pkg::result_t awaited[$];
        b64c_pkg::result_t step_out[$];
        int        errors;

        task report(string msg);
            errors++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        function void set_reg(b64c_pkg::cfg_reg_t idx, logic [15:0] v);
            case (idx)
                b64c_pkg::REG_DECODE_MODE:    decode_mode = v[0];
                b64c_pkg::REG_IGNORE_INVALID: ignore_invalid = v[0];
                b64c_pkg::REG_LINE_LENGTH:    line_length = v;
                default: ;
            endcase
        endfunction

        function void emit(bit [7:0] b, bit v, bit e);
            b64c_pkg::result_t r;
            r.out_byte  = b;
            r.out_valid = v;
            r.out_end   = 1'b0;
            r.out_error = e;
            step_out.push_back(r);
        endfunction

        function void clear_group();
            group_bits  = '0;
            group_count = 0;
        endfunction

        function void put_char(bit [7:0] c);
            if (line_length != 0 && first_char_done && line_count >= line_length)
            begin
                emit(b64c_pkg::CHAR_NEWLINE, 1'b1, 1'b0);
                line_count = '0;
            end
            emit(c, 1'b1, 1'b0);
            first_char_done = 1'b1;
            if (line_count != 16'hFFFF)
                line_count++;
        endfunction

        function void put_sextet(bit [23:0] v);
            put_char(alpha[int'(v[5:0])]);
        endfunction

        function int sextet_of(bit [7:0] c);
            for (int i = 0; i < 64; i++)
                if (alpha[i] == c)
                    return i;
            return -1;
        endfunction

        function void encode_flush();
            bit [23:0] v;
            if (group_count == 1)
            begin
                v = {group_bits[7:0], 16'h0000};
                put_sextet(v >> 18);
                put_sextet(v >> 12);
                put_char(b64c_pkg::CHAR_PAD);
                put_char(b64c_pkg::CHAR_PAD);
            end
            else if (group_count == 2)
            begin
                v = {group_bits[15:0], 8'h00};
                put_sextet(v >> 18);
                put_sextet(v >> 12);
                put_sextet(v >> 6);
                put_char(b64c_pkg::CHAR_PAD);
            end
            clear_group();
        endfunction

        function void encode_byte(bit [7:0] b, bit last);
            int cnt;
            cnt = group_count + 1;
            group_bits = {group_bits[15:0], b};
            if (cnt >= 3)
            begin
                put_sextet(group_bits >> 18);
                put_sextet(group_bits >> 12);
                put_sextet(group_bits >> 6);
                put_sextet(group_bits);
                clear_group();
            end
            else
                group_count = cnt;
            if (last)
                encode_flush();
        endfunction

        function void decode_flush();
            if (group_count == 2)
                emit(group_bits[11:4], 1'b1, 1'b0);
            else if (group_count == 3)
            begin
                emit(group_bits[17:10], 1'b1, 1'b0);
                emit(group_bits[9:2], 1'b1, 1'b0);
            end
            clear_group();
        endfunction

        function void decode_char(bit [7:0] c, bit last);
            int s;
            int cnt;
            if (stopped)
                return;
            if (c == b64c_pkg::CHAR_PAD)
            begin
                decode_flush();
                stopped = 1'b1;
                return;
            end
            s = sextet_of(c);
            if (s < 0)
            begin
                if (!ignore_invalid)
                begin
                    emit(8'h00, 1'b0, 1'b1);
                    clear_group();
                    stopped = 1'b1;
                    return;
                end
            end
            else
            begin
                cnt = group_count + 1;
                group_bits = {group_bits[17:0], 6'(s)};
                if (cnt >= 4)
                begin
                    emit(group_bits[23:16], 1'b1, 1'b0);
                    emit(group_bits[15:8], 1'b1, 1'b0);
                    emit(group_bits[7:0], 1'b1, 1'b0);
                    clear_group();
                end
                else
                    group_count = cnt;
            end
            if (last)
                decode_flush();
        endfunction

        function void take_in(b64c_pkg::item_t it);
            step_out.delete();
            if (decode_mode)
                decode_char(it.in_byte, it.in_last);
            else
                encode_byte(it.in_byte, it.in_last);
            if (it.in_last)
            begin
                if (step_out.size() == 0)
                    emit(8'h00, 1'b0, 1'b0);
                step_out[step_out.size() - 1].out_end = 1'b1;
                clear_group();
                line_count      = '0;
                first_char_done = 1'b0;
                stopped         = 1'b0;
            end
            foreach (step_out[i])
                awaited.push_back(step_out[i]);
        endfunction

        task check_out(b64c_pkg::result_t got);
            b64c_pkg::result_t want;
            if (awaited.size() == 0)
            begin
                report($sformatf("beat %h arrived with nothing awaited", got));
                return;
            end
            want = awaited.pop_front();
            if (got.out_byte !== want.out_byte)
                report($sformatf("out_byte %h, wanted %h", got.out_byte, want.out_byte));
            if (got.out_valid !== want.out_valid)
                report($sformatf("out_valid %b, wanted %b", got.out_valid, want.out_valid));
            if (got.out_end !== want.out_end)
                report($sformatf("out_end %b, wanted %b", got.out_end, want.out_end));
            if (got.out_error !== want.out_error)
                report($sformatf("out_error %b, wanted %b", got.out_error, want.out_error));
        endtask

        task close_out();
            if (awaited.size() != 0)
                report($sformatf("%0d beats never arrived", awaited.size()));
        endtask
    endclass

    logic     clk;
    logic     rst_n;
    logic     cfg_valid;
    logic     cfg_ready;
    b64c_pkg::cfg_reg_t cfg_index;
    logic     [15:0] cfg_data;
    logic     item_valid;
    logic     item_stall;
    b64c_pkg::item_t    in_beat;
    logic     result_valid;
    logic     result_stall;
    b64c_pkg::result_t  result;

    base64_mirror mirror = new();
    bit           calm;
    bit           hold_request;
    int           cycles;

    base64_codec_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (in_beat),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            mirror.check_out(result);
    end

    // Drain side: random hold per beat, one long hold on request
    initial
    begin
        int pause;
        result_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                result_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_request = 1'b0;
            end
            pause = calm ? 0 : $urandom_range(0, 5);
            result_stall = (pause != 0);
            repeat (pause) @(negedge clk);
            result_stall = 1'b0;
            do
                @(posedge clk);
            while (!result_valid);
        end
    end

    task automatic write_reg(b64c_pkg::cfg_reg_t idx, logic [15:0] v);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = v;
        do
            @(posedge clk);
        while (!cfg_ready);
        mirror.set_reg(idx, v);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_item(logic [7:0] b, logic last);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 5);
        if (gap != 0)
        begin
            item_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid      = 1'b1;
        in_beat.in_byte = b;
        in_beat.in_last = last;
        do
            @(posedge clk);
        while (item_stall);
        mirror.take_in(in_beat);
        @(negedge clk);
    endtask

    task automatic send_text(string s, bit close);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], close && i == s.len() - 1);
    endtask

    // Hold the input, wait for every awaited beat, then let the pipeline empty
    task automatic settle();
        item_valid = 1'b0;
        while (mirror.awaited.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return mirror.alpha[$urandom_range(0, 63)];
        else if (r < 86)
            return b64c_pkg::CHAR_PAD;
        else if (r < 90)
            return b64c_pkg::CHAR_NEWLINE;
        else
            return 8'($urandom_range(0, 255));
    endfunction

    initial
    begin
        bit         dm;
        bit         ign;
        logic [15:0] ll;
        logic [7:0] b;
        logic       last;
        bit         closing;
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = b64c_pkg::REG_DECODE_MODE;
        cfg_data     = '0;
        item_valid   = 1'b0;
        in_beat      = '0;
        calm         = 1'b0;
        hold_request = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_reg(b64c_pkg::REG_DECODE_MODE, 16'd0);
        write_reg(b64c_pkg::REG_IGNORE_INVALID, 16'd0);
        write_reg(b64c_pkg::REG_LINE_LENGTH, 16'd0);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h80, 1'b1);
        send_item(8'hFF, 1'b1);
        send_item(8'h01, 1'b0);
        send_item(8'hFE, 1'b1);
        settle();
        write_reg(b64c_pkg::REG_LINE_LENGTH, 16'd1);
        send_item(8'h55, 1'b0);
        send_item(8'hAA, 1'b1);
        settle();
        write_reg(b64c_pkg::REG_DECODE_MODE, 16'd1);
        send_text("+/0zAB=C", 1'b1);
        send_text("Q\nx-", 1'b1);
        send_text("Q", 1'b1);
        settle();
        write_reg(b64c_pkg::REG_IGNORE_INVALID, 16'd1);
        send_text("SG*k", 1'b1);

        for (int p = 0; p < 8; p++)
        begin
            settle();
            case (p)
                0:
                begin
                    dm = 1'b0; ign = 1'b0; ll = 16'd4;
                end
                1:
                begin
                    dm = 1'b1; ign = 1'b0; ll = 16'd0;
                end
                2:
                begin
                    dm = 1'b1; ign = 1'b1; ll = 16'd2;
                end
                3:
                begin
                    dm = 1'b0; ign = 1'b1; ll = 16'hFFFF;
                end
                4:
                begin
                    dm = 1'b0; ign = 1'b0; ll = 16'd3;
                end
                default:
                begin
                    dm  = $urandom_range(0, 1);
                    ign = $urandom_range(0, 1);
                    ll  = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                      : 16'($urandom_range(0, 8));
                end
            endcase
            write_reg(b64c_pkg::REG_DECODE_MODE, {15'd0, dm});
            write_reg(b64c_pkg::REG_IGNORE_INVALID, {15'd0, ign});
            write_reg(b64c_pkg::REG_LINE_LENGTH, ll);
            calm = (p == 5);
            if (p == 4)
                hold_request = 1'b1;
            closing = 1'b0;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (p == 2 && n == 7)
                    settle();
                b    = dm ? pick_char() : 8'($urandom_range(0, 255));
                last = closing || (n == PHASE_ITEMS - 1 && $urandom_range(0, 1) == 1)
                    || $urandom_range(0, 7) == 0;
                send_item(b, last);
                closing = dm && !last
                    && (b == b64c_pkg::CHAR_PAD || (!ign && mirror.sextet_of(b) < 0));
            end
        end
        calm = 1'b0;

        settle();
        mirror.close_out();
        if (mirror.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

[files.f]
hdl/b64c_pkg.sv
hdl/b64c_front.sv
hdl/b64c_queue.sv
hdl/b64c_back.sv
hdl/base64_codec_unit.sv
hdl/b64c_checker.sv
verif/tb_top.sv
